FILE: src/dfu_pkg.sv
// Shared types and constants of the digitizer fragment unpacker.
// No dependencies; every other file in src refers to this package by scoped names.
package dfu_pkg;

    localparam int WORD_W        = 16;
    localparam int OFFSET_W      = 8;
    localparam int TIME_W        = 48;
    localparam int SIZE_W        = 32;
    localparam int POSITION_W    = 6;

    localparam int OFS_PAYLOAD_HI = 27;
    localparam int OFS_CHANNEL    = 31;
    localparam int OFS_TIME0      = 32;
    localparam int OFS_TIME1      = 33;
    localparam int OFS_TIME2      = 34;
    localparam int OFS_ENERGY     = 41;
    localparam int OFS_SAMPLES    = 48;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 32'd166;

    // Hand-over of a completed good fragment from the parser to the emitter.
    typedef struct packed {
        logic              start;
        logic              bank;
        logic [WORD_W-1:0] channel;
        logic [WORD_W-1:0] energy;
        logic [TIME_W-1:0] timestamp;
    } emit_req_t;

endpackage

FILE: src/dfu_sample_mem.sv
// Two-bank waveform sample memory, one write port and one registered read port.
// Depends on dfu_pkg for the word width.
module dfu_sample_mem #(
    parameter int ADDR_W = 7
) (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [ADDR_W-1:0]          wr_addr,
    input  logic [dfu_pkg::WORD_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic [ADDR_W-1:0]          rd_addr,
    output logic [dfu_pkg::WORD_W-1:0] rd_data
);

    logic [dfu_pkg::WORD_W-1:0] mem [2**ADDR_W];
    logic [dfu_pkg::WORD_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/dfu_parser.sv
// Word parser: tracks buffer and fragment position, checks the payload size,
// captures header fields and writes samples into the sample memory. Depends on dfu_pkg.
module dfu_parser #(
    parameter int FRAGMENT_LENGTH = 190,
    parameter int SAMPLE_COUNT    = 64,
    parameter int SAMPLE_AW       = 6
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         word_accept,
    input  logic [dfu_pkg::WORD_W-1:0]   data_word,
    input  logic                         buffer_first,
    input  logic                         buffer_last,
    input  logic [dfu_pkg::SIZE_W-1:0]   expected_size,
    input  logic                         emit_busy,
    output logic                         word_ready,
    output logic                         mem_wr_en,
    output logic [SAMPLE_AW:0]           mem_wr_addr,
    output dfu_pkg::emit_req_t           emit_req
);

    localparam int SAMPLE_END = dfu_pkg::OFS_SAMPLES + 2 * SAMPLE_COUNT;
    localparam logic [dfu_pkg::OFFSET_W-1:0] LAST_OFS = dfu_pkg::OFFSET_W'(FRAGMENT_LENGTH - 1);

    logic [dfu_pkg::OFFSET_W-1:0] word_offset_reg, word_offset_next;
    logic                         in_buffer_reg, in_buffer_next;
    logic                         good_reg, good_next;
    logic                         bank_reg, bank_next;
    logic [dfu_pkg::WORD_W-1:0]   low_half_reg;
    logic [dfu_pkg::WORD_W-1:0]   channel_reg;
    logic [dfu_pkg::WORD_W-1:0]   energy_reg;
    logic [dfu_pkg::TIME_W-1:0]   time_reg;

    logic                         active;
    logic                         good_now;
    logic                         size_ok;
    logic                         at_end;
    logic [dfu_pkg::OFFSET_W-1:0] sample_rel;

    assign active     = word_accept && !buffer_first && in_buffer_reg;
    assign good_now   = (word_offset_reg == '0) ? 1'b0 : good_reg;
    assign size_ok    = ({data_word, low_half_reg} == expected_size);
    assign at_end     = (word_offset_reg >= LAST_OFS);
    assign sample_rel = word_offset_reg - dfu_pkg::OFFSET_W'(dfu_pkg::OFS_SAMPLES);

    // The word that closes a fragment waits while the previous fragment is still read out.
    assign word_ready = !(emit_busy && in_buffer_reg && word_offset_reg == LAST_OFS);

    assign mem_wr_en   = active && word_offset_reg >= dfu_pkg::OFFSET_W'(dfu_pkg::OFS_SAMPLES)
                         && word_offset_reg < dfu_pkg::OFFSET_W'(SAMPLE_END)
                         && !word_offset_reg[0];
    assign mem_wr_addr = {bank_reg, sample_rel[SAMPLE_AW:1]};

    always_comb begin
        word_offset_next = word_offset_reg;
        in_buffer_next   = in_buffer_reg;
        good_next        = good_reg;
        bank_next        = bank_reg;
        emit_req.start     = 1'b0;
        emit_req.bank      = bank_reg;
        emit_req.channel   = channel_reg;
        emit_req.energy    = energy_reg;
        emit_req.timestamp = time_reg;
        if (word_accept && buffer_first) begin
            in_buffer_next   = !buffer_last;
            word_offset_next = '0;
            good_next        = 1'b0;
        end else if (active) begin
            good_next = good_now;
            if (word_offset_reg == dfu_pkg::OFFSET_W'(dfu_pkg::OFS_PAYLOAD_HI)) begin
                good_next = size_ok;
            end
            if (word_offset_reg == dfu_pkg::OFFSET_W'(dfu_pkg::OFS_PAYLOAD_HI) && !size_ok) begin
                in_buffer_next   = 1'b0;
                word_offset_next = '0;
            end else begin
                if (at_end) begin
                    emit_req.start   = good_now;
                    bank_next        = bank_reg ^ good_now;
                    good_next        = 1'b0;
                    word_offset_next = '0;
                end else begin
                    word_offset_next = word_offset_reg + 1'b1;
                end
                if (buffer_last) begin
                    in_buffer_next   = 1'b0;
                    word_offset_next = '0;
                    good_next        = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_offset_reg <= '0;
            in_buffer_reg   <= 1'b0;
            good_reg        <= 1'b0;
            bank_reg        <= 1'b0;
        end else begin
            word_offset_reg <= word_offset_next;
            in_buffer_reg   <= in_buffer_next;
            good_reg        <= good_next;
            bank_reg        <= bank_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_half_reg <= '0;
            channel_reg  <= '0;
            energy_reg   <= '0;
            time_reg     <= '0;
        end else if (active) begin
            low_half_reg <= data_word;
            case (word_offset_reg)
                dfu_pkg::OFFSET_W'(dfu_pkg::OFS_CHANNEL): channel_reg      <= data_word;
                dfu_pkg::OFFSET_W'(dfu_pkg::OFS_TIME0):   time_reg[15:0]   <= data_word;
                dfu_pkg::OFFSET_W'(dfu_pkg::OFS_TIME1):   time_reg[31:16]  <= data_word;
                dfu_pkg::OFFSET_W'(dfu_pkg::OFS_TIME2):   time_reg[47:32]  <= data_word;
                dfu_pkg::OFFSET_W'(dfu_pkg::OFS_ENERGY):  energy_reg       <= data_word;
                default: ;
            endcase
        end
    end

endmodule

FILE: src/dfu_emitter.sv
// Read-out engine: walks one bank of the sample memory and drives the result registers.
// Depends on dfu_pkg; the sample value comes straight from the memory's read register.
module dfu_emitter #(
    parameter int SAMPLE_COUNT = 64,
    parameter int SAMPLE_AW    = 6
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  dfu_pkg::emit_req_t            emit_req,
    output logic                          emit_busy,
    output logic                          rd_en,
    output logic [SAMPLE_AW:0]            rd_addr,
    input  logic                          m_ready,
    output logic                          m_valid,
    output logic [dfu_pkg::WORD_W-1:0]    m_hit_channel,
    output logic [dfu_pkg::WORD_W-1:0]    m_hit_energy,
    output logic [dfu_pkg::TIME_W-1:0]    m_hit_time,
    output logic [dfu_pkg::POSITION_W-1:0] m_sample_position,
    output logic                          m_hit_last
);

    localparam int CW = $clog2(SAMPLE_COUNT + 1);

    logic [CW-1:0]              count_reg;
    logic [SAMPLE_AW-1:0]       index_reg;
    dfu_pkg::emit_req_t         meta_reg;
    logic                       valid_reg;
    logic [dfu_pkg::WORD_W-1:0] channel_reg;
    logic [dfu_pkg::WORD_W-1:0] energy_reg;
    logic [dfu_pkg::TIME_W-1:0] time_reg;
    logic [dfu_pkg::POSITION_W-1:0] position_reg;
    logic                       last_reg;

    assign emit_busy = (count_reg != '0);
    assign rd_en     = emit_busy && (!valid_reg || m_ready);
    assign rd_addr   = {meta_reg.bank, index_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            index_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (emit_req.start) begin
                count_reg <= CW'(SAMPLE_COUNT);
                index_reg <= '0;
            end else if (rd_en) begin
                count_reg <= count_reg - 1'b1;
                index_reg <= index_reg + 1'b1;
            end
            if (rd_en) begin
                valid_reg <= 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_req.start) begin
            meta_reg <= emit_req;
        end
        if (rd_en) begin
            channel_reg  <= meta_reg.channel;
            energy_reg   <= meta_reg.energy;
            time_reg     <= meta_reg.timestamp;
            position_reg <= dfu_pkg::POSITION_W'(index_reg);
            last_reg     <= (count_reg == CW'(1));
        end
    end

    assign m_valid           = valid_reg;
    assign m_hit_channel     = channel_reg;
    assign m_hit_energy      = energy_reg;
    assign m_hit_time        = time_reg;
    assign m_sample_position = position_reg;
    assign m_hit_last        = last_reg;

endmodule

FILE: src/digitizer_fragment_unpacker_top.sv
// Top level of the digitizer fragment unpacker: configuration register, parser,
// sample memory and read-out engine. Depends on dfu_pkg and the three dfu_ modules.

// The block takes one buffer word per cycle while s_ready is high. A good fragment of
// FRAGMENT_LENGTH words gives SAMPLE_COUNT results, one per cycle while m_ready is high,
// read from a two-bank sample memory so that the next fragment fills one bank while the
// other is read out. Input is held off only on the closing word of a fragment whose
// predecessor is still being read out, so with a ready sink the input runs at one word
// per cycle. The hand-over is registered in the read-out engine before samples are read.
module digitizer_fragment_unpacker_top #(
    parameter int FRAGMENT_LENGTH = 190,
    parameter int SAMPLE_COUNT    = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [dfu_pkg::SIZE_W-1:0]      cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [dfu_pkg::WORD_W-1:0]      s_data_word,
    input  logic                            s_buffer_first,
    input  logic                            s_buffer_last,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [dfu_pkg::WORD_W-1:0]      m_hit_channel,
    output logic [dfu_pkg::WORD_W-1:0]      m_hit_energy,
    output logic [dfu_pkg::TIME_W-1:0]      m_hit_time,
    output logic [dfu_pkg::POSITION_W-1:0]  m_sample_position,
    output logic [dfu_pkg::WORD_W-1:0]      m_sample_value,
    output logic                            m_hit_last
);

    localparam int SAMPLE_AW = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;

    logic [dfu_pkg::SIZE_W-1:0] expected_size_reg;
    logic                       word_accept;
    logic                       emit_busy;
    logic                       mem_wr_en;
    logic [SAMPLE_AW:0]         mem_wr_addr;
    logic                       rd_en;
    logic [SAMPLE_AW:0]         rd_addr;
    dfu_pkg::emit_req_t         emit_req;

    assign cfg_ready   = 1'b1;
    assign word_accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expected_size_reg <= dfu_pkg::SIZE_RESET;
        end else if (cfg_valid) begin
            expected_size_reg <= cfg_data;
        end
    end

    dfu_parser #(
        .FRAGMENT_LENGTH (FRAGMENT_LENGTH),
        .SAMPLE_COUNT    (SAMPLE_COUNT),
        .SAMPLE_AW       (SAMPLE_AW)
    ) u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .word_accept   (word_accept),
        .data_word     (s_data_word),
        .buffer_first  (s_buffer_first),
        .buffer_last   (s_buffer_last),
        .expected_size (expected_size_reg),
        .emit_busy     (emit_busy),
        .word_ready    (s_ready),
        .mem_wr_en     (mem_wr_en),
        .mem_wr_addr   (mem_wr_addr),
        .emit_req      (emit_req)
    );

    dfu_sample_mem #(
        .ADDR_W (SAMPLE_AW + 1)
    ) u_sample_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (s_data_word),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (m_sample_value)
    );

    dfu_emitter #(
        .SAMPLE_COUNT (SAMPLE_COUNT),
        .SAMPLE_AW    (SAMPLE_AW)
    ) u_emitter (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .emit_req          (emit_req),
        .emit_busy         (emit_busy),
        .rd_en             (rd_en),
        .rd_addr           (rd_addr),
        .m_ready           (m_ready),
        .m_valid           (m_valid),
        .m_hit_channel     (m_hit_channel),
        .m_hit_energy      (m_hit_energy),
        .m_hit_time        (m_hit_time),
        .m_sample_position (m_sample_position),
        .m_hit_last        (m_hit_last)
    );

    // A new fragment is only handed over once the previous read-out has been issued.
    a_start_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_req.start |-> !emit_busy)
        else $error("fragment handed over while read-out busy");

    // The filling bank and the bank being read are never the same.
    a_bank_split: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_wr_en && rd_en) |-> (mem_wr_addr[SAMPLE_AW] != rd_addr[SAMPLE_AW]))
        else $error("sample write and read in the same bank");

    a_last_position: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_hit_last) |->
            (m_sample_position == dfu_pkg::POSITION_W'(SAMPLE_COUNT - 1)))
        else $error("final result carries the wrong sample position");

endmodule
